// ===== sv/generation_tagged_slot_allocator_assert.svh =====
// Assertion macros for the slot allocator.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef GENERATION_TAGGED_SLOT_ALLOCATOR_ASSERT_SVH
`define GENERATION_TAGGED_SLOT_ALLOCATOR_ASSERT_SVH

// Condition holds at every edge outside reset.
`define GTSA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define GTSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/gtsa_pkg.sv =====
// Shared types and codes for the generation-tagged slot allocator.
// No dependencies.
package gtsa_pkg;

  typedef logic [1:0]  func_t;
  typedef logic [1:0]  status_t;
  typedef logic [9:0]  slot_t;
  typedef logic [31:0] gen_t;

  localparam func_t FUNC_ALLOC  = 2'd0;
  localparam func_t FUNC_FREE   = 2'd1;
  localparam func_t FUNC_RETAG  = 2'd2;
  localparam func_t FUNC_VERIFY = 2'd3;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_BAD_SLOT = 2'd2;
  localparam status_t ST_GEN_MISS = 2'd3;

  typedef struct packed {
    status_t status;
    slot_t   result_slot;
    gen_t    result_generation;
    slot_t   slots_in_use;
  } rsp_t;

endpackage

// ===== sv/gtsa_in_if.sv =====
// Request channel of the slot allocator: valid/ready plus the request item.
// Depends on gtsa_pkg.
interface gtsa_in_if;
  import gtsa_pkg::*;

  logic  valid;
  logic  ready;
  func_t func;
  slot_t slot_index;
  gen_t  check_generation;

  modport source (output valid, output func, output slot_index, output check_generation,
                  input ready);
  modport sink (input valid, input func, input slot_index, input check_generation,
                output ready);
endinterface

// ===== sv/gtsa_out_if.sv =====
// Result channel of the slot allocator: valid/ready plus the result item.
// Depends on gtsa_pkg.
interface gtsa_out_if;
  import gtsa_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  slot_t   result_slot;
  gen_t    result_generation;
  slot_t   slots_in_use;

  modport source (output valid, output status, output result_slot,
                  output result_generation, output slots_in_use, input ready);
  modport sink (input valid, input status, input result_slot,
                input result_generation, input slots_in_use, output ready);
endinterface

// ===== sv/generation_tagged_slot_allocator.sv =====
// Generation-tagged slot allocator: free list, generation and bound mark per slot.
// Depends on gtsa_pkg, gtsa_in_if, gtsa_out_if and the assertion macro header.
//
// Usage:
//   in_chan carries one request item (func, slot_index, check_generation);
//   out_chan returns exactly one result item for each request, in order.
//   func: alloc pops the free list head, free pushes a bound slot back,
//   retag bumps the generation of a bound slot, verify checks a handle.
//   An accepted request has its slot entry read into a register, and its
//   result is registered in the output register on commit. Requests are
//   limited by the single slot memory, whose entry is read on accept and
//   rewritten on commit; the next request is taken only after that write-back.
//   Reset (rst_n low, synchronous): free list 1..SLOTS-1, all generations
//   zero, nothing bound. No clearing pass: a fill mark tracks the highest
//   slot ever handed out, and entries above it read as their reset value.
//   Back-pressure: a result waits in the output register; one further
//   request is accepted and read meanwhile, then held until the output
//   register frees.
module generation_tagged_slot_allocator #(
  parameter int SLOTS = 1024
) (
  input logic        clk,
  input logic        rst_n,
  gtsa_in_if.sink    in_chan,
  gtsa_out_if.source out_chan
);
  import gtsa_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = 17;

  typedef struct packed {
    logic          bound;
    gen_t          gen;
    logic [SW-1:0] link;
  } entry_t;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  entry_t mem [SLOTS];

  logic          state_r, state_nxt;
  func_t         op_r;
  slot_t         slot_r;
  gen_t          chk_r;
  logic [SW-1:0] addr_r;
  logic [SW-1:0] head_r, head_nxt;
  logic [SW:0]   fill_r, fill_nxt;
  slot_t         cnt_r, cnt_nxt;
  entry_t        rd_r;
  rsp_t          out_r, rsp;
  logic          out_valid_r;

  logic          accept, commit, wr_req, fresh, in_range, usable;
  logic [SW-1:0] rd_addr, reset_link, pop_link;
  entry_t        eff, wr_data;
  gen_t          gen_inc;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept  = in_chan.valid && in_chan.ready;
  assign commit  = (state_r == S_EXEC) && (!out_valid_r || out_chan.ready);
  assign rd_addr = (in_chan.func == FUNC_ALLOC) ? head_r : SW'(in_chan.slot_index);

  // Slot 0 and anything at or above the fill mark were never written.
  assign fresh      = (addr_r == '0) || ({1'b0, addr_r} >= fill_r);
  assign reset_link = ((addr_r == '0) || (addr_r == SW'(SLOTS - 1))) ? '0
                                                                       : addr_r + SW'(1);
  always_comb begin
    if (fresh) begin
      eff.bound = 1'b0;
      eff.gen   = '0;
      eff.link  = reset_link;
    end else begin
      eff = rd_r;
    end
  end

  assign gen_inc  = eff.gen + 32'd1;
  assign in_range = CW'(slot_r) < CW'(SLOTS);
  assign usable   = in_range && (slot_r != '0) && eff.bound;
  assign pop_link = (CW'(eff.link) < CW'(SLOTS)) ? eff.link : '0;

  always_comb begin
    wr_req   = 1'b0;
    wr_data  = eff;
    head_nxt = head_r;
    fill_nxt = fill_r;
    cnt_nxt  = cnt_r;
    rsp.status            = ST_OK;
    rsp.result_slot       = '0;
    rsp.result_generation = '0;
    case (op_r)
      FUNC_ALLOC: begin
        if (head_r == '0) begin
          rsp.status = ST_EMPTY;
        end else begin
          wr_req        = 1'b1;
          wr_data.bound = 1'b1;
          wr_data.gen   = gen_inc;
          wr_data.link  = '0;
          head_nxt      = pop_link;
          if ({1'b0, addr_r} >= fill_r) begin
            fill_nxt = {1'b0, addr_r} + (SW + 1)'(1);
          end
          cnt_nxt               = cnt_r + 10'd1;
          rsp.result_slot       = 10'(addr_r);
          rsp.result_generation = gen_inc;
        end
      end
      FUNC_FREE: begin
        if (!usable) begin
          rsp.status = ST_BAD_SLOT;
        end else begin
          wr_req        = 1'b1;
          wr_data.bound = 1'b0;
          wr_data.gen   = gen_inc;
          wr_data.link  = head_r;
          head_nxt      = addr_r;
          cnt_nxt       = cnt_r - 10'd1;
          rsp.result_slot       = slot_r;
          rsp.result_generation = gen_inc;
        end
      end
      FUNC_RETAG: begin
        if (!usable) begin
          rsp.status = ST_BAD_SLOT;
        end else begin
          wr_req      = 1'b1;
          wr_data.gen = gen_inc;
          rsp.result_slot       = slot_r;
          rsp.result_generation = gen_inc;
        end
      end
      default: begin
        // verify: range, then generation, then bound mark
        if (!in_range) begin
          rsp.status = ST_BAD_SLOT;
        end else if (eff.gen != chk_r) begin
          rsp.status            = ST_GEN_MISS;
          rsp.result_slot       = slot_r;
          rsp.result_generation = eff.gen;
        end else if (!usable) begin
          rsp.status = ST_BAD_SLOT;
        end else begin
          rsp.result_slot       = slot_r;
          rsp.result_generation = eff.gen;
        end
      end
    endcase
    rsp.slots_in_use = cnt_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Slot memory: read on accept, write back on commit; the two never overlap.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= mem[rd_addr];
    end
    if (commit && wr_req) begin
      mem[addr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_chan.func;
      slot_r <= in_chan.slot_index;
      chk_r  <= in_chan.check_generation;
      addr_r <= rd_addr;
    end
    if (commit) begin
      out_r <= rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= SW'(1);
      fill_r      <= (SW + 1)'(1);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        head_r <= head_nxt;
        fill_r <= fill_nxt;
        cnt_r  <= cnt_nxt;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.status            = out_r.status;
  assign out_chan.result_slot       = out_r.result_slot;
  assign out_chan.result_generation = out_r.result_generation;
  assign out_chan.slots_in_use      = out_r.slots_in_use;

`include "generation_tagged_slot_allocator_assert.svh"

  `GTSA_ASSERT_ALWAYS(a_fill_bound, CW'(fill_r) <= CW'(SLOTS), "fill mark beyond slot count")
  `GTSA_ASSERT_ALWAYS(a_head_le_fill, ({1'b0, head_r} <= fill_r), "free head beyond fill mark")
  `GTSA_ASSERT_NEXT(a_commit_out, commit, out_valid_r && (state_r == S_IDLE), "result not loaded")

endmodule

// ===== tb/generation_tagged_slot_allocator_tb.sv =====
// Self-checking bench for the generation-tagged slot allocator: random and directed requests
// against a mirror of the handle table, with bursty sender and stalling receiver.
// Depends on gtsa_pkg, gtsa_in_if, gtsa_out_if and generation_tagged_slot_allocator.
module generation_tagged_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gtsa_pkg::*;

  localparam int SLOT_COUNT  = 1024;
  localparam int STALL_LIMIT = 500;
  localparam int PRINT_LIMIT = 20;

  // Mirror of the handle table: predicts each reply and checks the ones seen.
  class handle_table_mirror;
    slot_t link_of [SLOT_COUNT];
    gen_t  slot_gen [SLOT_COUNT];
    bit    slot_bound [SLOT_COUNT];
    slot_t head;
    slot_t in_use;
    rsp_t  predicted_rsp[$];
    int    mismatches;
    int    replies_checked;
    int    empty_hits;
    int    peak_in_use;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        link_of[i]    = (i == 0 || i == SLOT_COUNT - 1) ? slot_t'(0) : slot_t'(i + 1);
        slot_gen[i]   = '0;
        slot_bound[i] = 1'b0;
      end
      head            = slot_t'(1);
      in_use          = '0;
      mismatches      = 0;
      replies_checked = 0;
      empty_hits      = 0;
      peak_in_use     = 0;
    endfunction

    function bit usable(slot_t n);
      return n != 0 && int'(n) < SLOT_COUNT && slot_bound[n];
    endfunction

    function void take_request(func_t f, slot_t n, gen_t chk);
      rsp_t  r;
      slot_t h;
      r.status            = ST_BAD_SLOT;
      r.result_slot       = '0;
      r.result_generation = '0;
      case (f)
        FUNC_ALLOC: begin
          if (head == 0 || int'(head) >= SLOT_COUNT) begin
            r.status = ST_EMPTY;
            empty_hits++;
          end else begin
            h = head;
            head = (int'(link_of[h]) < SLOT_COUNT) ? link_of[h] : slot_t'(0);
            link_of[h]    = '0;
            slot_bound[h] = 1'b1;
            slot_gen[h]   = slot_gen[h] + 1;
            in_use        = in_use + slot_t'(1);
            r.status            = ST_OK;
            r.result_slot       = h;
            r.result_generation = slot_gen[h];
          end
        end
        FUNC_FREE: begin
          if (usable(n)) begin
            link_of[n]    = head;
            head          = n;
            in_use        = in_use - slot_t'(1);
            slot_gen[n]   = slot_gen[n] + 1;
            slot_bound[n] = 1'b0;
            r.status            = ST_OK;
            r.result_slot       = n;
            r.result_generation = slot_gen[n];
          end
        end
        FUNC_RETAG: begin
          if (usable(n)) begin
            slot_gen[n] = slot_gen[n] + 1;
            r.status            = ST_OK;
            r.result_slot       = n;
            r.result_generation = slot_gen[n];
          end
        end
        default: begin
          // range first, then generation, then the bound mark
          if (int'(n) < SLOT_COUNT) begin
            if (slot_gen[n] != chk) begin
              r.status            = ST_GEN_MISS;
              r.result_slot       = n;
              r.result_generation = slot_gen[n];
            end else if (usable(n)) begin
              r.status            = ST_OK;
              r.result_slot       = n;
              r.result_generation = slot_gen[n];
            end
          end
        end
      endcase
      r.slots_in_use = in_use;
      if (int'(in_use) > peak_in_use) peak_in_use = int'(in_use);
      predicted_rsp.push_back(r);
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
          $display("%0t: reply %0d %s mismatch, expected 0x%0h, actual 0x%0h",
                   $time, replies_checked, what, want, got);
      end
    endfunction

    function void check_result(status_t st, slot_t sl, gen_t g, slot_t cnt);
      rsp_t want;
      if (predicted_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
          $display("%0t: unrequested reply, expected none, actual status %0d slot %0d gen 0x%0h",
                   $time, st, sl, g);
        return;
      end
      want = predicted_rsp.pop_front();
      compare_field("status", 32'(want.status), 32'(st));
      compare_field("result_slot", 32'(want.result_slot), 32'(sl));
      compare_field("result_generation", want.result_generation, g);
      compare_field("slots_in_use", 32'(want.slots_in_use), 32'(cnt));
      replies_checked++;
    endfunction

    function slot_t pick_bound();
      int start;
      int s;
      if (in_use == 0) return '0;
      start = $urandom_range(1, SLOT_COUNT - 1);
      for (int i = 0; i < SLOT_COUNT - 1; i++) begin
        s = 1 + (start - 1 + i) % (SLOT_COUNT - 1);
        if (slot_bound[s]) return slot_t'(s);
      end
      return '0;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  gtsa_in_if  in_chan ();
  gtsa_out_if out_chan ();

  generation_tagged_slot_allocator #(.SLOTS(SLOT_COUNT)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  handle_table_mirror table_mirror = new();

  int    burst_left;
  int    requests_sent;
  int    idle_cycles = 0;
  int    ready_mode = 0;
  int    mode_left = 0;
  int    stall_left = 0;
  slot_t last_freed;
  gen_t  last_freed_gen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: check every accepted reply, then pick next ready from the current stall mode.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      table_mirror.check_result(out_chan.status, out_chan.result_slot,
                                out_chan.result_generation, out_chan.slots_in_use);
    if (rst_n && ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)))
      idle_cycles = 0;
    else if (rst_n)
      idle_cycles++;

    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 120);
    end
    mode_left--;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= ~out_chan.ready;
        2: out_chan.ready <= ($urandom_range(0, 9) < 7);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_chan.ready <= 1'b0;
          end else begin
            out_chan.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 15);
          end
        end
      endcase
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("generation_tagged_slot_allocator verification failed");
    $finish;
  end

  // Present one request, in bursts with random gaps, and hold it until taken.
  task automatic issue(func_t f, slot_t s, gen_t g);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_chan.valid            <= 1'b1;
    in_chan.func             <= f;
    in_chan.slot_index       <= s;
    in_chan.check_generation <= g;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    table_mirror.take_request(f, s, g);
    requests_sent++;
  endtask

  task automatic hold_until_drained();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (table_mirror.predicted_rsp.size() != 0) @(posedge clk);
  endtask

  // One request: mostly well-formed handle traffic, some noise and stale handles.
  task automatic send_mixed(int alloc_pct, int free_pct, int noise_pct);
    int    r;
    slot_t s;
    gen_t  g;
    r = $urandom_range(0, 99);
    s = table_mirror.pick_bound();
    if (r < alloc_pct || (s == 0 && r < alloc_pct + free_pct)) begin
      issue(FUNC_ALLOC, slot_t'($urandom_range(0, 1023)), gen_t'($urandom));
    end else if (r < alloc_pct + free_pct) begin
      last_freed     = s;
      last_freed_gen = table_mirror.slot_gen[s];
      issue(FUNC_FREE, s, gen_t'($urandom));
    end else if (r < alloc_pct + free_pct + noise_pct) begin
      case ($urandom_range(0, 3))
        0: issue(func_t'($urandom_range(0, 3)), slot_t'($urandom_range(0, 1023)),
                 gen_t'($urandom));
        1: begin
          // replay a handle that has since been freed
          if (last_freed == 0)
            issue(FUNC_VERIFY, slot_t'($urandom_range(0, 1023)), gen_t'($urandom));
          else if ($urandom_range(0, 1) == 0)
            issue(FUNC_FREE, last_freed, gen_t'($urandom));
          else
            issue(FUNC_VERIFY, last_freed, last_freed_gen);
        end
        2: issue(func_t'($urandom_range(1, 3)), '0,
                 ($urandom_range(0, 1) == 0) ? gen_t'(0) : gen_t'($urandom));
        default: begin
          s = slot_t'($urandom_range(1, SLOT_COUNT - 1));
          issue(FUNC_VERIFY, s, table_mirror.slot_gen[s]);
        end
      endcase
    end else if (s == 0) begin
      issue(FUNC_ALLOC, slot_t'($urandom_range(0, 1023)), gen_t'($urandom));
    end else begin
      g = table_mirror.slot_gen[s];
      case ($urandom_range(0, 4))
        0, 1: issue(FUNC_VERIFY, s, g);
        2: issue(FUNC_RETAG, s, gen_t'($urandom));
        3: issue(FUNC_VERIFY, s, ($urandom_range(0, 1) == 0) ? g - 1 : g + 1);
        default: issue(FUNC_VERIFY, s, g ^ (gen_t'(1) << $urandom_range(0, 31)));
      endcase
    end
  endtask

  initial begin
    int    faults;
    slot_t s;
    rst_n                    <= 1'b0;
    in_chan.valid            <= 1'b0;
    in_chan.func             <= FUNC_ALLOC;
    in_chan.slot_index       <= '0;
    in_chan.check_generation <= '0;
    burst_left     = 0;
    requests_sent  = 0;
    last_freed     = '0;
    last_freed_gen = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reserved slot, unbound slots, stale handles, double free, field extremes
    issue(FUNC_VERIFY, '0, '0);
    issue(FUNC_VERIFY, slot_t'(1023), 32'hFFFF_FFFF);
    issue(FUNC_VERIFY, '0, 32'hFFFF_FFFF);
    issue(FUNC_FREE, '0, '0);
    issue(FUNC_RETAG, slot_t'(5), '0);
    issue(FUNC_FREE, slot_t'(1023), 32'hFFFF_FFFF);
    issue(FUNC_ALLOC, slot_t'(1023), 32'hFFFF_FFFF);
    issue(FUNC_ALLOC, '0, '0);
    issue(FUNC_RETAG, slot_t'(1), '0);
    issue(FUNC_VERIFY, slot_t'(1), 32'd2);
    issue(FUNC_VERIFY, slot_t'(1), 32'd1);
    issue(FUNC_FREE, slot_t'(1), '0);
    issue(FUNC_FREE, slot_t'(1), '0);
    issue(FUNC_VERIFY, slot_t'(1), 32'd3);
    issue(FUNC_ALLOC, '0, '0);
    issue(FUNC_VERIFY, slot_t'(2), 32'hFFFF_FFFF);
    issue(FUNC_RETAG, '0, '0);
    issue(FUNC_VERIFY, slot_t'(2), 32'd1);
    issue(FUNC_FREE, slot_t'(2), '0);
    issue(FUNC_FREE, slot_t'(1), '0);

    repeat (300) send_mixed(40, 15, 15);
    hold_until_drained();

    // fill the table, then hit the empty free list
    while (table_mirror.in_use != slot_t'(SLOT_COUNT - 1)) send_mixed(92, 1, 3);
    repeat (4) issue(FUNC_ALLOC, slot_t'($urandom_range(0, 1023)), gen_t'($urandom));
    s = table_mirror.pick_bound();
    issue(FUNC_FREE, s, '0);
    issue(FUNC_ALLOC, '0, '0);
    issue(FUNC_ALLOC, '0, '0);
    hold_until_drained();

    repeat (250) send_mixed(15, 45, 15);

    hold_until_drained();
    repeat (8) @(posedge clk);

    $display("%0d requests sent, %0d replies checked", requests_sent,
             table_mirror.replies_checked);
    $display("free list found empty %0d times, peak of %0d slots bound",
             table_mirror.empty_hits, table_mirror.peak_in_use);
    faults = table_mirror.mismatches + table_mirror.predicted_rsp.size();
    if (faults == 0)
      $display("generation_tagged_slot_allocator verification clean");
    else
      $display("generation_tagged_slot_allocator verification failed");
    $finish;
  end

endmodule
